// File: src/assert_macros.svh
// Assertion macros shared by the clipper RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("forbidden state");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// File: src/hpc_pkg.sv
// Package for the homogeneous polygon clipper: sizes, state enum, vertex type.
// No dependencies; imported by every clipper module.
package hpc_pkg;
  localparam int MaxInVerts = 16;
  localparam int NumPlanes  = 6;
  localparam int StoreDepth = MaxInVerts + NumPlanes;
  localparam int IdxW       = $clog2(StoreDepth);
  localparam int CntW       = $clog2(StoreDepth + 1);
  localparam int VertW      = 4 * 32 + 3 * 16;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
    logic [15:0] r;
    logic [15:0] g;
    logic [15:0] b;
  } vert_t;

  typedef enum logic [3:0] {
    ST_LOAD, ST_PSTART, ST_RDA, ST_RDB, ST_CAPB, ST_DIST, ST_DIV, ST_LERP, ST_WRX,
    ST_WRB, ST_NEXT, ST_ORD, ST_OUT, ST_EMPTY
  } state_t;

  // division request / status between sequencer and divider
  typedef struct packed {
    logic        start;
    logic [33:0] num;
    logic [33:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic [16:0] q;
  } div_rsp_t;

  function automatic logic signed [32:0] plane_coord(vert_t v, logic [2:0] p);
    logic signed [32:0] c;
    c = (p[2:1] == 2'd0) ? 33'(v.x) : (p[2:1] == 2'd1) ? 33'(v.y) : 33'(v.z);
    return p[0] ? (33'(v.w) - c) : (c + 33'(v.w));
  endfunction
endpackage

// File: src/hpc_div.sv
// Restoring divider for the crossing parameter: one quotient bit per cycle.
// Depends on hpc_pkg; computes min(floor(num*65536/den), 65536) for num < den.
module hpc_div
  import hpc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic [33:0] rem_r, rem_nxt;
  logic [33:0] den_r;
  logic [16:0] q_r, q_nxt;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic [34:0] trial;

  // remainder stays below den, so it always fits in 34 bits
  always_comb begin
    trial   = {rem_r, 1'b0};
    rem_nxt = trial[33:0];
    q_nxt   = {q_r[15:0], 1'b0};
    if (trial >= {1'b0, den_r}) begin
      rem_nxt = 34'(trial - {1'b0, den_r});
      q_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= 5'd16;
    end else if (busy_r) begin
      if (cnt_r == 5'd1) busy_r <= 1'b0;
      cnt_r <= cnt_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.num;
      den_r <= req.den;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.q    = q_r;

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_div_len, clk, rst_n, req.start |=> busy_r)
  `ASSERT_NEVER(a_no_restart, clk, rst_n, req.start && busy_r)
  `ASSERT_IMPL(a_q_range, clk, rst_n, $fell(busy_r) |-> q_r <= 17'd65535)
endmodule

// File: src/hpc_lerp.sv
// Shared interpolation unit: one component per cycle, a + round((b-a)*t/65536).
// Depends on hpc_pkg; the multiply is registered before the rounding add.
module hpc_lerp
  import hpc_pkg::*;
(
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  input  logic [16:0]        t,
  output logic signed [32:0] res
);
  logic signed [33:0] diff;
  logic signed [51:0] prod_r;
  logic signed [32:0] a_r;
  logic signed [51:0] u;

  assign diff = 34'(a) - 34'(b) == 34'sd0 ? 34'sd0 : 34'(b) - 34'(a);

  always_ff @(posedge clk) begin
    prod_r <= 52'(diff) * $signed({35'd0, t});
    a_r    <= a;
  end

  // arithmetic shift gives floor, which with +0.5 is round half up
  assign u   = prod_r + 52'sd32768;
  assign res = a_r + 33'(u >>> 16);
endmodule

// File: src/homogeneous_polygon_clipper_core.sv
// Homogeneous polygon clipper top level: sequencer, ping-pong stores, ports.
// Depends on hpc_pkg, hpc_div, hpc_lerp and assert_macros.svh.
//
// Usage: vertices enter on the in_ stream, one transfer per ready cycle; in_tdata
// holds x, y, z, w, r, g, b and in_tlast marks the final vertex. Up to 16
// vertices are kept, extra ones dropped. After the last vertex the block clips
// against left, right, bottom, top, near and far, and is not ready meanwhile.
// Each pass reads both ends of every edge, checks their plane distances and
// writes the kept end; a crossing also runs the bit-serial divider (skipped
// when t saturates) and the shared interpolator, then writes the new vertex.
// Each output vertex is read from the store, then presented.
// Results leave on the out_ stream, out_tlast on the final vertex and
// out_tuser set on the single item given for a fully clipped polygon.
// A stalled receiver holds the block in its output state, data held steady.
// Reset (synchronous, rst_n low) empties the vertex count and returns to
// loading; store contents stay undefined until written.
module homogeneous_polygon_clipper_core
  import hpc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [175:0] in_tdata,   // x, y, z, w, r, g, b from bit 0
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [175:0] out_tdata,  // x, y, z, w, r, g, b from bit 0
  output logic         out_tlast,
  output logic         out_tuser   // empty flag
);
  // two stores of vertices; bank selects source
  vert_t mem_a [StoreDepth];
  vert_t mem_b [StoreDepth];

  state_t st_r, st_nxt;
  logic [CntW-1:0] n_r, m_r, i_r;
  logic [2:0] p_r;
  vert_t va_r, vb_r, vx_r, rd_r;
  logic signed [33:0] sa_r, sb_r;
  logic [2:0] k_r;
  logic [16:0] t_r;
  logic div_used_r;
  div_req_t dreq;
  div_rsp_t drsp;
  logic signed [32:0] la, lb, lres;

  logic [IdxW-1:0] rd_idx, wr_idx;
  logic [IdxW-1:0] j_idx;
  logic [CntW-1:0] i_inc;
  logic src_a;
  logic we;
  vert_t wdata, in_vert;
  logic aout, bout;
  logic [33:0] mn, md;
  logic signed [33:0] den;

  assign src_a = ~p_r[0];
  assign i_inc = i_r + 1'b1;
  assign j_idx = (i_inc < n_r) ? i_inc[IdxW-1:0] : '0;
  assign aout  = sa_r[33];
  assign bout  = sb_r[33];
  assign den   = sa_r - sb_r;
  assign mn    = sa_r[33] ? 34'(-sa_r) : 34'(sa_r);
  assign md    = den[33] ? 34'(-den) : 34'(den);

  assign in_vert = '{x: in_tdata[31:0], y: in_tdata[63:32], z: in_tdata[95:64],
                     w: in_tdata[127:96], r: in_tdata[143:128],
                     g: in_tdata[159:144], b: in_tdata[175:160]};

  // memory read address
  always_comb begin
    case (st_r)
      ST_RDA:  rd_idx = i_r[IdxW-1:0];
      ST_RDB:  rd_idx = j_idx;
      default: rd_idx = i_r[IdxW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (src_a || st_r == ST_ORD || st_r == ST_OUT) rd_r <= mem_a[rd_idx];
    else rd_r <= mem_b[rd_idx];
  end

  // writes: load into A, passes into the other bank
  always_comb begin
    we = 1'b0;
    wdata = in_vert;
    wr_idx = n_r[IdxW-1:0];
    case (st_r)
      ST_LOAD: we = in_tvalid && n_r < CntW'(MaxInVerts);
      ST_WRX: begin
        we = m_r < CntW'(StoreDepth);
        wdata = vx_r;
        wr_idx = m_r[IdxW-1:0];
      end
      ST_WRB: begin
        we = !bout && m_r < CntW'(StoreDepth);
        wdata = vb_r;
        wr_idx = m_r[IdxW-1:0];
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we && (st_r == ST_LOAD || !src_a)) mem_a[wr_idx] <= wdata;
    if (we && st_r != ST_LOAD && src_a) mem_b[wr_idx] <= wdata;
  end

  assign dreq.start = (st_r == ST_DIST) && (aout != bout) && !(den == 0) &&
                      !(sa_r[33] != den[33] && sa_r != 0) && mn < md;
  assign dreq.num = mn;
  assign dreq.den = md;

  hpc_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // interpolator operand select, one component per k
  always_comb begin
    case (k_r)
      3'd0: begin la = 33'(va_r.x); lb = 33'(vb_r.x); end
      3'd1: begin la = 33'(va_r.y); lb = 33'(vb_r.y); end
      3'd2: begin la = 33'(va_r.z); lb = 33'(vb_r.z); end
      3'd3: begin la = 33'(va_r.w); lb = 33'(vb_r.w); end
      3'd4: begin la = $signed({17'd0, va_r.r}); lb = $signed({17'd0, vb_r.r}); end
      3'd5: begin la = $signed({17'd0, va_r.g}); lb = $signed({17'd0, vb_r.g}); end
      default: begin la = $signed({17'd0, va_r.b}); lb = $signed({17'd0, vb_r.b}); end
    endcase
  end

  hpc_lerp u_lerp (.clk(clk), .a(la), .b(lb), .t(t_r), .res(lres));

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_LOAD:   if (in_tvalid && in_tlast) st_nxt = ST_PSTART;
      ST_PSTART: st_nxt = (n_r == 0) ? ST_NEXT : ST_RDA;
      ST_RDA:    st_nxt = ST_RDB;
      ST_RDB:    st_nxt = ST_CAPB;
      ST_CAPB:   st_nxt = ST_DIST;
      ST_DIST:   st_nxt = (aout != bout) ? ST_DIV : ST_WRB;
      ST_DIV:    if (!drsp.busy) st_nxt = ST_LERP;
      ST_LERP:   if (k_r == 3'd7) st_nxt = ST_WRX;
      ST_WRX:    st_nxt = ST_WRB;
      ST_WRB:    st_nxt = (i_inc >= n_r) ? ST_NEXT : ST_RDA;
      ST_NEXT:   st_nxt = (p_r == 3'd5) ? ((m_r == 0) ? ST_EMPTY : ST_ORD) : ST_PSTART;
      ST_ORD:    st_nxt = ST_OUT;
      ST_OUT:    if (out_tready) st_nxt = (i_inc >= n_r) ? ST_LOAD : ST_ORD;
      ST_EMPTY:  if (out_tready) st_nxt = ST_LOAD;
      default:   st_nxt = ST_LOAD;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_LOAD;
      n_r  <= '0;
      m_r  <= '0;
      i_r  <= '0;
      p_r  <= '0;
      k_r  <= '0;
    end else begin
      st_r <= st_nxt;
      case (st_r)
        ST_LOAD: if (in_tvalid) begin
          if (n_r < CntW'(MaxInVerts)) n_r <= n_r + 1'b1;
        end
        ST_PSTART: begin
          i_r <= '0;
          m_r <= '0;
        end
        ST_DIST: k_r <= '0;
        ST_LERP: k_r <= k_r + 3'd1;
        ST_WRX: if (m_r < CntW'(StoreDepth)) m_r <= m_r + 1'b1;
        ST_WRB: begin
          if (!bout && m_r < CntW'(StoreDepth)) m_r <= m_r + 1'b1;
          i_r <= i_inc;
        end
        ST_NEXT: begin
          n_r <= m_r;
          i_r <= '0;
          if (p_r == 3'd5) p_r <= '0;
          else p_r <= p_r + 3'd1;
        end
        ST_OUT: if (out_tready) begin
          i_r <= i_inc;
          if (i_inc >= n_r) n_r <= '0;
        end
        ST_EMPTY: if (out_tready) n_r <= '0;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (st_r)
      ST_RDB: begin
        va_r <= rd_r;
        sa_r <= 34'(plane_coord(rd_r, p_r));
      end
      ST_CAPB: begin
        vb_r <= rd_r;
        sb_r <= 34'(plane_coord(rd_r, p_r));
      end
      ST_DIST: begin
        div_used_r <= dreq.start;
        if (den == 0 || (sa_r[33] != den[33] && sa_r != 0)) t_r <= '0;
        else if (mn >= md) t_r <= 17'd65536;
      end
      ST_DIV: if (!drsp.busy && div_used_r) t_r <= drsp.q;
      // interpolated components land in the cycle after their select
      ST_LERP: begin
        case (k_r)
          3'd1: vx_r.x <= lres[31:0];
          3'd2: vx_r.y <= lres[31:0];
          3'd3: vx_r.z <= lres[31:0];
          3'd4: vx_r.w <= lres[31:0];
          3'd5: vx_r.r <= lres[15:0];
          3'd6: vx_r.g <= lres[15:0];
          3'd7: vx_r.b <= lres[15:0];
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // output
  assign in_tready  = (st_r == ST_LOAD);
  assign out_tvalid = (st_r == ST_OUT) || (st_r == ST_EMPTY);
  assign out_tuser  = (st_r == ST_EMPTY);
  assign out_tlast  = (st_r == ST_EMPTY) || (i_inc >= n_r);
  assign out_tdata  = (st_r == ST_EMPTY) ? '0 :
                      {rd_r.b, rd_r.g, rd_r.r, rd_r.w, rd_r.z, rd_r.y, rd_r.x};

  `include "assert_macros.svh"
  `ASSERT_NEVER(a_ready_excl, clk, rst_n, in_tready && out_tvalid)
  `ASSERT_NEVER(a_cnt_max, clk, rst_n, n_r > CntW'(StoreDepth))
  `ASSERT_IMPL(a_plane_rng, clk, rst_n, p_r <= 3'd5)
endmodule
